// ===== hw/rtl/lpad_pkg.sv =====
package lpad_pkg;

    // Magic length in bytes; the magic is the fixed signature, padded with zero bytes.
    localparam int MAGIC_LENGTH = 11;
    localparam int MAGIC_IDX_W  = (MAGIC_LENGTH > 1) ? $clog2(MAGIC_LENGTH) : 1;

    localparam int COUNT_W       = 32;
    localparam int NAME_LEN_W    = 32;
    localparam int PAYLOAD_LEN_W = 41;
    // Bytes left in a field: large enough for any accepted payload length.
    localparam int FIELD_LEFT_W  = 41;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 41;

    localparam logic [CFG_INDEX_W-1:0] CFG_NAME_LIMIT    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LIMIT = 4'd1;

    localparam logic [NAME_LEN_W-1:0]    NAME_LIMIT_RESET    = 32'd4096;
    localparam logic [PAYLOAD_LEN_W-1:0] PAYLOAD_LIMIT_RESET = 41'd1073741824;

    // Parser phases; a byte's role is the phase it was parsed in.
    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_COUNT   = 3'd1;
    localparam logic [2:0] PH_NLEN    = 3'd2;
    localparam logic [2:0] PH_NAME    = 3'd3;
    localparam logic [2:0] PH_PLEN    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_IGNORE  = 3'd6;

    // Status codes; the error codes double as the sticky error register values.
    localparam logic [2:0] ST_RUNNING       = 3'd0;
    localparam logic [2:0] ST_OK            = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC     = 3'd2;
    localparam logic [2:0] ST_NAME_LONG     = 3'd3;
    localparam logic [2:0] ST_PAYLOAD_LONG  = 3'd4;
    localparam logic [2:0] ST_TRUNCATED     = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } lpad_item_t;

    typedef struct packed {
        logic [2:0]         byte_role;
        logic [COUNT_W-1:0] entry_number;
        logic               field_end;
        logic [2:0]         status;
        logic               archive_done;
    } lpad_result_t;

    typedef struct packed {
        logic [NAME_LEN_W-1:0]    name_limit;
        logic [PAYLOAD_LEN_W-1:0] payload_limit;
    } lpad_limits_t;

    function automatic logic [7:0] magic_byte(input logic [MAGIC_IDX_W-1:0] idx);
        logic [7:0] value;
        case (int'(idx))
            0:       value = 8'h42;
            1:       value = 8'h41;
            2:       value = 8'h54;
            3:       value = 8'h42;
            4:       value = 8'h41;
            5:       value = 8'h43;
            6:       value = 8'h4B;
            7:       value = 8'h55;
            8:       value = 8'h50;
            9:       value = 8'h31;
            10:      value = 8'h0A;
            default: value = 8'h00;
        endcase
        return value;
    endfunction

endpackage

// ===== hw/rtl/lpad_item_if.sv =====
interface lpad_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// ===== hw/rtl/lpad_result_if.sv =====
interface lpad_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [31:0] entry_number;
    logic        field_end;
    logic [2:0]  status;
    logic        archive_done;

    modport source (output valid, output byte_role, output entry_number, output field_end,
                    output status, output archive_done, input ready);
    modport sink   (input valid, input byte_role, input entry_number, input field_end,
                    input status, input archive_done, output ready);
endinterface

// ===== hw/rtl/lpad_cfg_if.sv =====
interface lpad_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [40:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lpad_cfg_regs.sv =====
module lpad_cfg_regs
    import lpad_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output lpad_limits_t           limits
);

    logic [NAME_LEN_W-1:0]    name_limit_reg;
    logic [PAYLOAD_LEN_W-1:0] payload_limit_reg;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_limit_reg    <= NAME_LIMIT_RESET;
            payload_limit_reg <= PAYLOAD_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == CFG_NAME_LIMIT)
            begin
                name_limit_reg <= wr_data[NAME_LEN_W-1:0];
            end
            if (wr_index == CFG_PAYLOAD_LIMIT)
            begin
                payload_limit_reg <= wr_data[PAYLOAD_LEN_W-1:0];
            end
        end
    end

    assign limits.name_limit    = name_limit_reg;
    assign limits.payload_limit = payload_limit_reg;

endmodule

// ===== hw/rtl/lpad_parser.sv =====
module lpad_parser
    import lpad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  lpad_item_t   item,
    input  lpad_limits_t limits,
    output lpad_result_t result
);

    logic [2:0]              phase_reg, phase_next;
    logic [FIELD_LEFT_W-1:0] left_reg, left_next;
    logic [PAYLOAD_LEN_W-1:0] asm_reg, asm_next;
    logic                    asm_high_reg, asm_high_next;
    logic [COUNT_W-1:0]      entries_left_reg, entries_left_next;
    logic [COUNT_W-1:0]      entry_count_reg, entry_count_next;
    logic [2:0]              error_reg, error_next;

    logic                    active;
    logic                    last_byte;
    logic [FIELD_LEFT_W-1:0] left_dec;
    logic [MAGIC_IDX_W-1:0]  magic_idx;
    logic [3:0]              field_width;
    logic [2:0]              pos;
    logic [63:0]             shifted;
    logic [PAYLOAD_LEN_W-1:0] asm_new;
    logic                    high_new;
    logic                    name_over;
    logic                    payload_over;
    logic                    do_finish;
    logic [COUNT_W-1:0]      entries_dec;

    assign active      = (error_reg == ST_RUNNING) && (phase_reg != PH_IGNORE);
    assign last_byte   = (left_reg == FIELD_LEFT_W'(1));
    assign left_dec    = left_reg - FIELD_LEFT_W'(1);
    assign magic_idx   = MAGIC_IDX_W'(FIELD_LEFT_W'(MAGIC_LENGTH) - left_reg);
    assign field_width = (phase_reg == PH_PLEN) ? 4'd8 : 4'd4;
    assign pos         = 3'(field_width - left_reg[3:0]);
    assign shifted     = 64'(item.data_byte) << {pos, 3'b000};
    assign asm_new     = asm_reg | shifted[PAYLOAD_LEN_W-1:0];
    // Any bit above the payload length width already exceeds every limit.
    assign high_new    = asm_high_reg | (|shifted[63:PAYLOAD_LEN_W]);
    assign name_over   = asm_new[NAME_LEN_W-1:0] > limits.name_limit;
    assign payload_over = high_new || (asm_new > limits.payload_limit);
    assign entries_dec = entries_left_reg - COUNT_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        left_next         = left_reg;
        asm_next          = asm_reg;
        asm_high_next     = asm_high_reg;
        entries_left_next = entries_left_reg;
        entry_count_next  = entry_count_reg;
        error_next        = error_reg;
        do_finish         = 1'b0;

        result.byte_role    = PH_IGNORE;
        result.entry_number = '0;
        result.field_end    = 1'b0;
        result.status       = ST_RUNNING;
        result.archive_done = item.is_last;

        if (active)
        begin
            result.byte_role = phase_reg;
            result.field_end = last_byte;
            if (phase_reg >= PH_NLEN)
            begin
                result.entry_number = entry_count_reg;
            end

            case (phase_reg)
                PH_MAGIC:
                begin
                    left_next = left_dec;
                    if (item.data_byte != magic_byte(magic_idx))
                    begin
                        error_next = ST_BAD_MAGIC;
                        phase_next = PH_IGNORE;
                    end
                    else if (last_byte)
                    begin
                        phase_next    = PH_COUNT;
                        left_next     = FIELD_LEFT_W'(4);
                        asm_next      = '0;
                        asm_high_next = 1'b0;
                    end
                end
                PH_NAME, PH_PAYLOAD:
                begin
                    left_next = left_dec;
                    if (last_byte)
                    begin
                        if (phase_reg == PH_NAME)
                        begin
                            phase_next    = PH_PLEN;
                            left_next     = FIELD_LEFT_W'(8);
                            asm_next      = '0;
                            asm_high_next = 1'b0;
                        end
                        else
                        begin
                            do_finish = 1'b1;
                        end
                    end
                end
                PH_COUNT, PH_NLEN, PH_PLEN:
                begin
                    asm_next      = asm_new;
                    asm_high_next = high_new;
                    left_next     = left_dec;
                    if (last_byte)
                    begin
                        if (phase_reg == PH_COUNT)
                        begin
                            entries_left_next = asm_new[COUNT_W-1:0];
                            entry_count_next  = '0;
                            if (asm_new[COUNT_W-1:0] == '0)
                            begin
                                phase_next = PH_IGNORE;
                            end
                            else
                            begin
                                phase_next    = PH_NLEN;
                                left_next     = FIELD_LEFT_W'(4);
                                asm_next      = '0;
                                asm_high_next = 1'b0;
                            end
                        end
                        else if (phase_reg == PH_NLEN)
                        begin
                            if (name_over)
                            begin
                                error_next = ST_NAME_LONG;
                                phase_next = PH_IGNORE;
                            end
                            else if (asm_new[NAME_LEN_W-1:0] == '0)
                            begin
                                phase_next    = PH_PLEN;
                                left_next     = FIELD_LEFT_W'(8);
                                asm_next      = '0;
                                asm_high_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_NAME;
                                left_next  = FIELD_LEFT_W'(asm_new[NAME_LEN_W-1:0]);
                            end
                        end
                        else
                        begin
                            if (payload_over)
                            begin
                                error_next = ST_PAYLOAD_LONG;
                                phase_next = PH_IGNORE;
                            end
                            else if (asm_new == '0)
                            begin
                                do_finish = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                                left_next  = FIELD_LEFT_W'(asm_new);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Closing an entry: advance the entry number and either stop or
            // start the next name length field.
            if (do_finish)
            begin
                entry_count_next  = entry_count_reg + COUNT_W'(1);
                entries_left_next = entries_dec;
                if (entries_dec == '0)
                begin
                    phase_next = PH_IGNORE;
                end
                else
                begin
                    phase_next    = PH_NLEN;
                    left_next     = FIELD_LEFT_W'(4);
                    asm_next      = '0;
                    asm_high_next = 1'b0;
                end
            end
        end

        // The final byte reports the outcome and rearms for the next archive.
        if (item.is_last)
        begin
            if (error_next != ST_RUNNING)
            begin
                result.status = error_next;
            end
            else if (phase_next == PH_IGNORE)
            begin
                result.status = ST_OK;
            end
            else
            begin
                result.status = ST_TRUNCATED;
            end
            phase_next        = PH_MAGIC;
            left_next         = FIELD_LEFT_W'(MAGIC_LENGTH);
            asm_next          = '0;
            asm_high_next     = 1'b0;
            entries_left_next = '0;
            entry_count_next  = '0;
            error_next        = ST_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_MAGIC;
            left_reg         <= FIELD_LEFT_W'(MAGIC_LENGTH);
            asm_reg          <= '0;
            asm_high_reg     <= 1'b0;
            entries_left_reg <= '0;
            entry_count_reg  <= '0;
            error_reg        <= ST_RUNNING;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            left_reg         <= left_next;
            asm_reg          <= asm_next;
            asm_high_reg     <= asm_high_next;
            entries_left_reg <= entries_left_next;
            entry_count_reg  <= entry_count_next;
            error_reg        <= error_next;
        end
    end

endmodule

// ===== hw/rtl/length_prefixed_archive_deframer.sv =====
// Archive deframer: takes one archive byte per beat and returns one tagged beat per byte,
// in order. Each output beat gives the byte's role, its entry number, an end-of-field
// mark and, on the beat marked is_last, the final status of the archive; the block then
// rearms for the next archive while the limit registers keep their values. Throughput is
// one byte per clock cycle while the result channel is ready. A byte is captured in the
// input register, and the parser's state update between the input and result registers
// loads its result into the result register, from which the output beat is presented.
// The limit registers are written through the configuration channel, which is always
// ready, and should only be written while no archive bytes are in flight.
module length_prefixed_archive_deframer
    import lpad_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lpad_item_if.sink     item,
    lpad_result_if.source result,
    lpad_cfg_if.sink      cfg
);

    lpad_limits_t limits;
    lpad_item_t   item_reg;
    logic         item_valid_reg, item_valid_next;
    lpad_result_t parsed;
    lpad_result_t result_reg;
    logic         result_valid_reg, result_valid_next;
    logic         item_take;
    logic         step;

    // Configuration writes complete in the cycle they are offered.
    assign cfg.ready = 1'b1;

    lpad_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .limits   (limits)
    );

    // A byte moves from the input register through the parser into the result register
    // whenever the result register is empty or being drained in the same cycle.
    assign step       = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || step;
    assign item_take  = item.valid && item.ready;

    assign item_valid_next   = item_take || (item_valid_reg && !step);
    assign result_valid_next = step || (result_valid_reg && !result.ready);

    lpad_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .limits (limits),
        .result (parsed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.data_byte <= item.data_byte;
            item_reg.is_last   <= item.is_last;
        end
        if (step)
        begin
            result_reg <= parsed;
        end
    end

    assign result.valid        = result_valid_reg;
    assign result.byte_role    = result_reg.byte_role;
    assign result.entry_number = result_reg.entry_number;
    assign result.field_end    = result_reg.field_end;
    assign result.status       = result_reg.status;
    assign result.archive_done = result_reg.archive_done;

endmodule

// ===== tb/tb_length_prefixed_archive_deframer.sv =====
module tb_length_prefixed_archive_deframer;
    import lpad_pkg::*;

    // The fixed signature, first byte in the lowest lane. Magic positions past its end
    // are zero bytes.
    localparam logic [87:0] SIGNATURE = {8'h0A, 8'h31, 8'h50, 8'h55, 8'h4B, 8'h43,
                                         8'h41, 8'h42, 8'h54, 8'h41, 8'h42};
    localparam logic [40:0] PAYLOAD_LIMIT_TOP = 41'h100_0000_0000;

    logic clk;
    logic rst_n;

    lpad_item_if   item_ch ();
    lpad_result_if result_ch ();
    lpad_cfg_if    cfg_ch ();

    length_prefixed_archive_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Parser state as the testbench tracks it. The error register holds ST_RUNNING
    // while no error has been latched for the current archive.
    logic [2:0]               arc_phase;
    logic [63:0]              bytes_left;
    logic [63:0]              len_acc;
    logic [31:0]              entries_left;
    logic [31:0]              entry_idx;
    logic [2:0]               err_code;
    logic [NAME_LEN_W-1:0]    name_lim;
    logic [PAYLOAD_LEN_W-1:0] payload_lim;

    // Beats waiting to be sent, and the tagged beats the block still owes us.
    lpad_item_t   byte_backlog[$];
    lpad_result_t expected_tags[$];
    logic [7:0]   arch_bytes[$];

    int unsigned mismatches;
    int unsigned items_queued;

    // Handshake bookkeeping: the beat flags are captured at the rising edge and read by
    // the falling-edge drivers.
    logic        item_beat;
    logic        res_beat;
    logic        in_flight;
    lpad_item_t  cur_item;
    int unsigned gap_left;
    int unsigned stall_left;
    logic        send_calm;
    logic        recv_calm;

    function automatic logic [7:0] signature_byte(int unsigned idx);
        if (idx < 11)
            return SIGNATURE[8*idx +: 8];
        return 8'h00;
    endfunction

    function void clear_archive();
        arc_phase    = PH_MAGIC;
        bytes_left   = 64'(MAGIC_LENGTH);
        len_acc      = '0;
        entries_left = '0;
        entry_idx    = '0;
        err_code     = ST_RUNNING;
    endfunction

    function void open_field(logic [2:0] next_phase, logic [63:0] width);
        arc_phase  = next_phase;
        bytes_left = width;
        len_acc    = '0;
    endfunction

    // An entry is complete once its payload is consumed (or skipped when empty).
    function void close_entry();
        entry_idx    = entry_idx + 32'd1;
        entries_left = entries_left - 32'd1;
        if (entries_left == 0)
            arc_phase = PH_IGNORE;
        else
            open_field(PH_NLEN, 64'd4);
    endfunction

    // Advances the tracked parser by one archive byte and returns the tag it should get.
    function automatic lpad_result_t deframe_byte(logic [7:0] b, logic last);
        lpad_result_t tag;
        int unsigned  idx;
        int unsigned  width;
        int unsigned  pos;
        tag = '0;
        tag.byte_role = PH_IGNORE;
        if (err_code == ST_RUNNING && arc_phase < PH_IGNORE) begin
            tag.byte_role = arc_phase;
            if (arc_phase >= PH_NLEN)
                tag.entry_number = entry_idx;
            tag.field_end = (bytes_left == 64'd1);
            if (arc_phase == PH_MAGIC) begin
                idx = MAGIC_LENGTH - int'(bytes_left);
                bytes_left = bytes_left - 64'd1;
                if (b != signature_byte(idx)) begin
                    err_code  = ST_BAD_MAGIC;
                    arc_phase = PH_IGNORE;
                end else if (bytes_left == 0) begin
                    open_field(PH_COUNT, 64'd4);
                end
            end else if (arc_phase == PH_NAME || arc_phase == PH_PAYLOAD) begin
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 0) begin
                    if (arc_phase == PH_NAME)
                        open_field(PH_PLEN, 64'd8);
                    else
                        close_entry();
                end
            end else begin
                // Little-endian length fields: count, name length, payload length.
                width = (arc_phase == PH_PLEN) ? 8 : 4;
                pos = width - int'(bytes_left[3:0]);
                len_acc = len_acc | (64'(b) << (8 * pos));
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 0) begin
                    if (arc_phase == PH_COUNT) begin
                        entries_left = len_acc[31:0];
                        entry_idx = '0;
                        if (entries_left == 0)
                            arc_phase = PH_IGNORE;
                        else
                            open_field(PH_NLEN, 64'd4);
                    end else if (arc_phase == PH_NLEN) begin
                        if (len_acc[31:0] > name_lim) begin
                            err_code  = ST_NAME_LONG;
                            arc_phase = PH_IGNORE;
                        end else if (len_acc[31:0] == 0) begin
                            open_field(PH_PLEN, 64'd8);
                        end else begin
                            arc_phase  = PH_NAME;
                            bytes_left = {32'd0, len_acc[31:0]};
                        end
                    end else begin
                        if (len_acc > {23'd0, payload_lim}) begin
                            err_code  = ST_PAYLOAD_LONG;
                            arc_phase = PH_IGNORE;
                        end else if (len_acc == 0) begin
                            close_entry();
                        end else begin
                            arc_phase  = PH_PAYLOAD;
                            bytes_left = len_acc;
                        end
                    end
                end
            end
        end
        if (last) begin
            // A latched error wins over the truncation report.
            if (err_code != ST_RUNNING)
                tag.status = err_code;
            else if (arc_phase == PH_IGNORE)
                tag.status = ST_OK;
            else
                tag.status = ST_TRUNCATED;
            clear_archive();
        end
        tag.archive_done = last;
        return tag;
    endfunction

    // Clock; the single reset pulse at the start of the run comes from the stimulus block below.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Input driver. Each beat, once accepted, is followed by a drawn number of idle
    // cycles; now and then the driver switches into a calm stretch with no gaps at all.
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_flight && item_beat)
                in_flight = 1'b0;
            if (!in_flight) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_backlog.size() != 0) begin
                    cur_item  = byte_backlog.pop_front();
                    in_flight = 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        send_calm = !send_calm;
                    gap_left = send_calm ? 0 : $urandom_range(0, 19);
                end
            end
            item_ch.valid     <= in_flight;
            item_ch.data_byte <= cur_item.data_byte;
            item_ch.is_last   <= cur_item.is_last;
        end
    end

    // Result-side backpressure: after every beat taken, ready drops for a drawn number
    // of cycles, again with calm stretches where it stays high.
    always @(negedge clk) begin
        if (rst_n) begin
            if (res_beat) begin
                if ($urandom_range(0, 49) == 0)
                    recv_calm = !recv_calm;
                stall_left = recv_calm ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor. A result beat is checked against the oldest expectation before the
    // tag of an input beat accepted at the same edge is queued.
    always @(posedge clk) begin
        lpad_result_t want;
        if (!rst_n) begin
            item_beat <= 1'b0;
            res_beat  <= 1'b0;
        end else begin
            item_beat <= item_ch.valid && item_ch.ready;
            res_beat  <= result_ch.valid && result_ch.ready;
            if (result_ch.valid && result_ch.ready) begin
                if (expected_tags.size() == 0) begin
                    $error("result beat with no byte outstanding");
                    mismatches++;
                end else begin
                    want = expected_tags.pop_front();
                    if (result_ch.byte_role !== want.byte_role) begin
                        $error("byte_role: expected %0d, got %0d",
                               want.byte_role, result_ch.byte_role);
                        mismatches++;
                    end
                    if (result_ch.entry_number !== want.entry_number) begin
                        $error("entry_number: expected %0d, got %0d",
                               want.entry_number, result_ch.entry_number);
                        mismatches++;
                    end
                    if (result_ch.field_end !== want.field_end) begin
                        $error("field_end: expected %0d, got %0d",
                               want.field_end, result_ch.field_end);
                        mismatches++;
                    end
                    if (result_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, result_ch.status);
                        mismatches++;
                    end
                    if (result_ch.archive_done !== want.archive_done) begin
                        $error("archive_done: expected %0d, got %0d",
                               want.archive_done, result_ch.archive_done);
                        mismatches++;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
                expected_tags.push_back(deframe_byte(item_ch.data_byte, item_ch.is_last));
        end
    end

    task automatic add_le(logic [63:0] value, int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            arch_bytes.push_back(value[8*k +: 8]);
    endtask

    task automatic add_random(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            arch_bytes.push_back(8'($urandom));
    endtask

    task automatic add_signature();
        for (int unsigned k = 0; k < MAGIC_LENGTH; k++)
            arch_bytes.push_back(signature_byte(k));
    endtask

    // Name lengths are mostly short and legal; some land exactly on a small limit and
    // some go over it, either by one or by a random amount.
    function automatic logic [31:0] pick_name_len();
        int unsigned r;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 7 && name_lim != '1) begin
            len = (r < 3) ? name_lim + 32'd1 : 32'($urandom);
            if (len <= name_lim)
                len = name_lim + 32'd1;
        end else if (r < 15 && name_lim <= 8) begin
            len = name_lim;
        end else begin
            len = $urandom_range(0, (name_lim < 6) ? name_lim : 6);
        end
        return len;
    endfunction

    function automatic logic [63:0] pick_payload_len();
        int unsigned r;
        logic [63:0] lim;
        logic [63:0] len;
        r = $urandom_range(0, 99);
        lim = {23'd0, payload_lim};
        if (r < 7) begin
            len = (r < 3) ? lim + 64'd1 : {32'($urandom), 32'($urandom)};
            if (len <= lim)
                len = lim + 64'd1;
        end else if (r < 15 && lim <= 10) begin
            len = lim;
        end else begin
            len = $urandom_range(0, (lim < 8) ? int'(lim) : 8);
        end
        return len;
    endfunction

    task automatic emit_archive();
        lpad_item_t beat;
        foreach (arch_bytes[k]) begin
            beat.data_byte = arch_bytes[k];
            beat.is_last   = (k == arch_bytes.size() - 1);
            byte_backlog.push_back(beat);
        end
        items_queued += arch_bytes.size();
    endtask

    // One archive of random shape. Most are well formed with random content; the rest
    // are cut short, carry a corrupted magic byte, announce huge counts or payloads and
    // stop early, or are plain noise.
    task automatic build_archive();
        int unsigned kind;
        int unsigned n_ent;
        int unsigned cut;
        int unsigned spot;
        logic [31:0] nlen;
        logic [63:0] plen;
        logic [63:0] draw;
        arch_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            add_random($urandom_range(1, 12));
        end else begin
            add_signature();
            if (kind >= 88) begin
                add_le({32'd0, 32'($urandom)}, 4);
                nlen = $urandom_range(0, (name_lim < 4) ? name_lim : 4);
                add_le({32'd0, nlen}, 4);
                add_random(nlen);
                draw = {32'($urandom), 32'($urandom)};
                plen = draw % ({23'd0, payload_lim} + 64'd1);
                add_le(plen, 8);
                add_random((plen < 6) ? int'(plen) : 6);
            end else begin
                n_ent = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
                add_le(64'(n_ent), 4);
                for (int unsigned e = 0; e < n_ent; e++) begin
                    nlen = pick_name_len();
                    add_le({32'd0, nlen}, 4);
                    if (nlen > name_lim)
                        break;
                    add_random(nlen);
                    plen = pick_payload_len();
                    add_le(plen, 8);
                    if (plen > {23'd0, payload_lim})
                        break;
                    add_random(int'(plen));
                end
                // Trailing bytes, ignored by the block.
                add_random($urandom_range(0, 2));
            end
            if (kind >= 80 && kind < 88) begin
                spot = $urandom_range(0, MAGIC_LENGTH - 1);
                arch_bytes[spot] = signature_byte(spot) ^ 8'($urandom_range(1, 255));
            end
            if (kind >= 70 && kind < 88 && arch_bytes.size() > 1 && $urandom_range(0, 1)) begin
                cut = $urandom_range(1, arch_bytes.size() - 1);
                while (arch_bytes.size() > cut)
                    void'(arch_bytes.pop_back());
            end
        end
        emit_archive();
    endtask

    task automatic run_archives(int unsigned amount);
        int unsigned stop_at;
        stop_at = items_queued + amount;
        while (items_queued < stop_at)
            build_archive();
    endtask

    // Everything sent and every tag received, then a settling wait for the pipeline.
    task automatic wait_idle();
        while (byte_backlog.size() != 0 || in_flight || expected_tags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes both limit registers back to back, holding valid high across the two beats.
    task automatic program_limits(logic [31:0] name_value, logic [40:0] payload_value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_NAME_LIMIT;
        cfg_ch.data  <= {9'($urandom), name_value};
        do @(posedge clk); while (!cfg_ch.ready);
        name_lim = name_value;
        @(negedge clk);
        cfg_ch.index <= CFG_PAYLOAD_LIMIT;
        cfg_ch.data  <= payload_value;
        do @(posedge clk); while (!cfg_ch.ready);
        payload_lim = payload_value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [40:0] rand_payload;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.data_byte = '0;
        item_ch.is_last   = 1'b0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_NAME_LIMIT;
        cfg_ch.data       = '0;
        item_beat         = 1'b0;
        res_beat          = 1'b0;
        in_flight         = 1'b0;
        cur_item          = '0;
        gap_left          = 0;
        stall_left        = 0;
        send_calm         = 1'b0;
        recv_calm         = 1'b0;
        mismatches        = 0;
        items_queued      = 0;
        name_lim          = NAME_LIMIT_RESET;
        payload_lim       = PAYLOAD_LIMIT_RESET;
        clear_archive();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed archives under the reset limits. A wrong first byte that is also the
        // last one reports a bad magic.
        arch_bytes = {8'h00};
        emit_archive();
        // An archive with no entries is complete right after its count; the trailing
        // bytes are ignored and the archive still ends as a success.
        arch_bytes.delete();
        add_signature();
        add_le(64'd0, 4);
        arch_bytes.push_back(8'hFF);
        arch_bytes.push_back(8'h00);
        emit_archive();
        // A correct first magic byte that ends the stream is a truncation.
        arch_bytes = {8'h42};
        emit_archive();

        run_archives(150);

        // Zero limits: any nonempty name or payload is rejected.
        wait_idle();
        program_limits(32'd0, 41'd0);
        run_archives(150);

        // Large limits: no name can be too long; huge payloads in range end truncated.
        wait_idle();
        program_limits('1, PAYLOAD_LIMIT_TOP);
        run_archives(150);

        // Small limits so that lengths land on and just past the boundary.
        wait_idle();
        program_limits(32'd3, 41'd5);
        run_archives(170);

        wait_idle();
        rand_payload = {9'($urandom), 32'($urandom)};
        if (rand_payload[40])
            rand_payload[39:0] = '0;
        program_limits(32'($urandom), rand_payload);
        run_archives(150);

        wait_idle();
        program_limits(NAME_LIMIT_RESET, PAYLOAD_LIMIT_RESET);
        run_archives(150);

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #4800000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lpad_pkg.sv
hw/rtl/lpad_item_if.sv
hw/rtl/lpad_result_if.sv
hw/rtl/lpad_cfg_if.sv
hw/rtl/lpad_cfg_regs.sv
hw/rtl/lpad_parser.sv
hw/rtl/length_prefixed_archive_deframer.sv
tb/tb_length_prefixed_archive_deframer.sv
